/* rtl/core/fixed_partition_worst_fit_allocator_core_assert.svh */
// Assertion macros shared by the fixed-partition allocator RTL.
`ifndef FIXED_PARTITION_WORST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_PARTITION_WORST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FPWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FPWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define FPWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/fpwf_pkg.sv */
// Shared constants, codes and interface types of the fixed-partition allocator.
package fpwf_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SLOT_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  typedef enum logic [2:0] {
    ST_CREATED   = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_ALLOCATED = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  typedef struct packed {
    logic        start;
    logic        def_en;
    logic        def_ok;
    logic        take_en;
    logic [15:0] size;
  } srch_cmd_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] best_idx;
    logic [15:0]       best_size;
    logic [CNT_W-1:0]  slot_cnt;
  } srch_stat_t;

endpackage

/* rtl/core/fpwf_search.sv */
// Partition table with its size memory and the sequential worst-fit search.
`include "fixed_partition_worst_fit_allocator_core_assert.svh"

module fpwf_search
  import fpwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  srch_cmd_t  cmd,
  output srch_stat_t stat
);

  logic [15:0] size_mem [MAX_PARTITIONS];
  logic [15:0] rd_data_r;
  logic [MAX_PARTITIONS-1:0] usable_r;
  logic [MAX_PARTITIONS-1:0] taken_r;
  logic [CNT_W-1:0] slot_cnt_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [SLOT_W-1:0] best_idx_r;
  logic [SLOT_W-1:0] def_idx;
  logic [15:0] best_size_r;
  logic scanning_r;
  logic rd_vld_r;
  logic found_r;
  logic done_r;
  logic slot_free;
  logic issue;
  logic cand;

  assign def_idx   = slot_cnt_r[SLOT_W-1:0];
  assign slot_free = slot_cnt_r < CNT_W'(MAX_PARTITIONS);
  assign issue     = scanning_r && (rd_cnt_r < slot_cnt_r);
  assign cand      = rd_vld_r && usable_r[rd_idx_r] && !taken_r[rd_idx_r] &&
                     (!found_r || (rd_data_r > best_size_r));

  always_ff @(posedge clk) begin
    if (cmd.def_en && cmd.def_ok && slot_free) begin
      size_mem[def_idx] <= cmd.size;
    end
    if (issue) begin
      rd_data_r <= size_mem[rd_cnt_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= rd_cnt_r[SLOT_W-1:0];
    end
    if (cand) begin
      best_idx_r  <= rd_idx_r;
      best_size_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r   <= '0;
      taken_r    <= '0;
      slot_cnt_r <= '0;
      rd_cnt_r   <= '0;
      scanning_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cand) begin
        found_r <= 1'b1;
      end
      if (cmd.start) begin
        scanning_r <= 1'b1;
        rd_cnt_r   <= '0;
        found_r    <= 1'b0;
        done_r     <= 1'b0;
      end else if (scanning_r) begin
        if (issue) begin
          rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          scanning_r <= 1'b0;
          done_r     <= 1'b1;
        end
      end
      if (cmd.def_en && slot_free) begin
        usable_r[def_idx] <= cmd.def_ok;
        taken_r[def_idx]  <= 1'b0;
        slot_cnt_r        <= slot_cnt_r + CNT_W'(1);
      end
      if (cmd.take_en) begin
        taken_r[best_idx_r] <= 1'b1;
      end
    end
  end

  assign stat.done      = done_r;
  assign stat.found     = found_r;
  assign stat.best_idx  = best_idx_r;
  assign stat.best_size = best_size_r;
  assign stat.slot_cnt  = slot_cnt_r;

  `FPWF_ASSERT_NOW(a_taken_usable, clk, rst_n, 1'b1, (taken_r & ~usable_r) == '0, "taken slot not usable")
  `FPWF_ASSERT_NOW(a_done_idle, clk, rst_n, done_r, !scanning_r && !rd_vld_r, "search done while busy")
  `FPWF_ASSERT_NOW(a_rd_in_range, clk, rst_n, rd_vld_r, CNT_W'(rd_idx_r) < slot_cnt_r, "read beyond defined slots")

endmodule

/* rtl/core/fixed_partition_worst_fit_allocator_core.sv */
// Fixed-partition worst-fit allocator: beat handshakes, counters and result register.
// A define beat goes from idle straight to the finish state; a process beat first waits
// in the scan state for the search, which reads one entry of the partition size memory
// per cycle. One beat is worked on at a time; the next is taken while a result still
// waits.
`include "fixed_partition_worst_fit_allocator_core_assert.svh"

module fixed_partition_worst_fit_allocator_core
  import fpwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_total_memory,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_partition_number,
  output logic [15:0] out_process_number,
  output logic [15:0] out_waste,
  output logic [31:0] out_total_waste,
  output logic [15:0] out_free_space
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  function automatic logic [15:0] space_fn(input logic [15:0] total, input logic [15:0] used);
    return (used >= total) ? 16'd0 : (total - used);
  endfunction

  state_t state_r, state_nxt;
  logic [15:0] total_memory_r;
  logic [15:0] used_r, used_nxt;
  logic [15:0] proc_cnt_r, proc_cnt_nxt;
  logic [31:0] waste_sum_r, waste_sum_nxt;
  logic        req_type_r;
  logic [15:0] req_size_r;
  logic        out_valid_r;
  status_t     out_status_r, status_nxt;
  logic [4:0]  out_pnum_r, pnum_nxt;
  logic [15:0] out_procnum_r, procnum_nxt;
  logic [15:0] out_waste_r, waste_nxt;
  logic [15:0] out_free_r;
  logic        out_free;
  logic        fin;
  logic        full;
  logic        def_fit;
  logic        grant;
  logic [15:0] waste_calc;
  logic [32:0] wsum;
  logic [15:0] space_now;
  srch_cmd_t   cmd;
  srch_stat_t  stat;

  fpwf_search u_search (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign fin       = (state_r == S_FIN) && out_free;

  assign space_now  = space_fn(total_memory_r, used_r);
  assign full       = !(stat.slot_cnt < CNT_W'(MAX_PARTITIONS));
  assign def_fit    = req_size_r <= space_now;
  assign grant      = stat.found && (req_size_r <= stat.best_size);
  assign waste_calc = stat.best_size - req_size_r;
  assign wsum       = {1'b0, waste_sum_r} + {17'd0, waste_calc};

  assign cmd.start   = in_valid && in_ready && in_req_type;
  assign cmd.def_en  = fin && !req_type_r && !full;
  assign cmd.def_ok  = def_fit;
  assign cmd.take_en = fin && req_type_r && grant;
  assign cmd.size    = req_size_r;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    proc_cnt_nxt  = proc_cnt_r;
    waste_sum_nxt = waste_sum_r;
    status_nxt    = ST_NONE;
    pnum_nxt      = 5'd0;
    procnum_nxt   = 16'd0;
    waste_nxt     = 16'd0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_req_type ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (stat.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (!req_type_r) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = def_fit ? ST_CREATED : ST_REJECTED;
        pnum_nxt   = 5'(stat.slot_cnt) + 5'd1;
        if (def_fit) begin
          used_nxt = used_r + req_size_r;
        end
      end
    end else begin
      proc_cnt_nxt = (proc_cnt_r == 16'hFFFF) ? proc_cnt_r : proc_cnt_r + 16'd1;
      procnum_nxt  = proc_cnt_nxt;
      if (grant) begin
        status_nxt    = ST_ALLOCATED;
        pnum_nxt      = 5'(stat.best_idx) + 5'd1;
        waste_nxt     = waste_calc;
        waste_sum_nxt = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      total_memory_r <= 16'd0;
      used_r         <= 16'd0;
      proc_cnt_r     <= 16'd0;
      waste_sum_r    <= 32'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        total_memory_r <= cfg_total_memory;
      end
      if (fin) begin
        used_r      <= used_nxt;
        proc_cnt_r  <= proc_cnt_nxt;
        waste_sum_r <= waste_sum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_type_r <= in_req_type;
      req_size_r <= in_size;
    end
    if (fin) begin
      out_status_r  <= status_nxt;
      out_pnum_r    <= pnum_nxt;
      out_procnum_r <= procnum_nxt;
      out_waste_r   <= waste_nxt;
      out_free_r    <= space_fn(total_memory_r, used_nxt);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_partition_number = out_pnum_r;
  assign out_process_number   = out_procnum_r;
  assign out_waste            = out_waste_r;
  assign out_total_waste      = waste_sum_r;
  assign out_free_space       = out_free_r;

  `FPWF_ASSERT_NEXT(a_fin_loads, clk, rst_n, fin, out_valid_r, "finished beat not presented")
  `FPWF_ASSERT_NEXT(a_proc_scans, clk, rst_n, in_valid && in_ready && in_req_type, state_r == S_SCAN, "process beat skipped search")
  `FPWF_ASSERT_NOW(a_alloc_slot, clk, rst_n, out_valid_r && (out_status_r == ST_ALLOCATED), (out_pnum_r != 5'd0) && (out_procnum_r != 16'd0), "grant without slot or process")

endmodule
